>>> hdl/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// ssnf_pkg
// Types, segment tables and glyph lookups shared by the number formatter.
// ----------------------------------------------------------------------------
package ssnf_pkg;

	typedef enum logic [1:0] {
		MODE_SDEC = 2'd0,
		MODE_UDEC = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_TEXT = 2'd3
	} mode_t;

	typedef struct packed {
		logic        valid;
		mode_t       mode;
		logic [31:0] mag;
		logic        neg;
		logic        sign_done;
		logic [63:0] text;
		logic [63:0] seg;
	} stage_t;

	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] SEG_MINUS = 8'h40;
	localparam logic [7:0] SEG_UNDER = 8'h08;
	localparam logic [7:0] SEG_EQUAL = 8'h48;

	// reciprocal of ten, exact for 32-bit operands with a shift of 35
	localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;

	localparam logic [7:0] DEC_SEG [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	localparam logic [7:0] ALPHA_SEG [26] = '{
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06,
		8'h1E, 8'h75, 8'h38, 8'h37, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50,
		8'h6D, 8'h78, 8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B
	};

	function automatic logic [7:0] nib_glyph(input logic [3:0] nib);
		logic [7:0] g;
		if (nib < 4'd10) begin
			g = DEC_SEG[nib];
		end else begin
			g = ALPHA_SEG[5'(nib - 4'd10)];
		end
		return g;
	endfunction

	function automatic logic [7:0] char_glyph(input logic [7:0] ch);
		logic [7:0] g;
		g = SEG_BLANK;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			g = DEC_SEG[4'(ch - 8'h30)];
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			g = ALPHA_SEG[5'(ch - 8'h41)];
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			g = ALPHA_SEG[5'(ch - 8'h61)];
		end else if (ch == 8'h2D) begin
			g = SEG_MINUS;
		end else if (ch == 8'h5F) begin
			g = SEG_UNDER;
		end else if (ch == 8'h3D) begin
			g = SEG_EQUAL;
		end
		return g;
	endfunction

endpackage

>>> hdl/ssnf_cell.sv
// ----------------------------------------------------------------------------
// ssnf_cell
// One digit position: peels one decimal digit or nibble off the magnitude,
// or looks up one text character, and writes its segment byte.
// ----------------------------------------------------------------------------
module ssnf_cell import ssnf_pkg::*; #(
	parameter int POS       = 0,
	parameter bit RIGHTMOST = 1'b0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t prev,
	output stage_t next
);

	logic [63:0] prod;
	logic [31:0] quot;
	logic [31:0] rem_full;
	logic [3:0]  digit;
	logic [7:0]  glyph_b;
	logic        ended;
	stage_t      next_d;

	assign prod     = 64'(prev.mag) * 64'(DIV10_MUL);
	assign quot     = 32'(prod[63:DIV10_SHIFT]);
	assign rem_full = prev.mag - ((quot << 3) + (quot << 1));
	assign digit    = (prev.mode == MODE_HEX) ? prev.mag[3:0] : rem_full[3:0];

	always_comb begin
		ended = 1'b0;
		for (int j = 0; j < 8; j++) begin
			if (j <= POS && prev.text[8*j +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
	end

	always_comb begin
		next_d     = prev;
		next_d.mag = (prev.mode == MODE_HEX) ? (prev.mag >> 4) : quot;
		glyph_b    = SEG_BLANK;
		case (prev.mode)
			MODE_SDEC: begin
				if (prev.mag != 32'd0 || RIGHTMOST) begin
					glyph_b = nib_glyph(digit);
				end else if (prev.neg && !prev.sign_done) begin
					glyph_b          = SEG_MINUS;
					next_d.sign_done = 1'b1;
				end
			end
			MODE_UDEC, MODE_HEX: begin
				glyph_b = nib_glyph(digit);
			end
			MODE_TEXT: begin
				glyph_b = ended ? SEG_BLANK : char_glyph(prev.text[8*POS +: 8]);
			end
			default: begin
				glyph_b = SEG_BLANK;
			end
		endcase
		next_d.seg[8*POS +: 8] = glyph_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next <= '0;
		end else begin
			next <= next_d;
		end
	end

endmodule

>>> hdl/seven_segment_number_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// Formats a number or a string into seven-segment codes for a row of digits.
// ----------------------------------------------------------------------------
//   channel   ports                            handshake
//   request   mode, value, text_chars          start, busy
//   result    segments                         done (one-cycle strobe)
//
// One transaction per cycle; busy is never raised.
// Each request passes an input register, then one cell per
// digit, rightmost first, each with its own divide-by-ten multiplier.
// Reset clears the valid bits of the chain; data in flight is dropped.
// The receiver cannot stall: done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter import ssnf_pkg::*; #(
	parameter int DIGIT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] value,
	input  logic [63:0] text_chars,
	output logic        done,
	output logic [63:0] segments
);

	localparam int RIGHT_LSB = 8 * (DIGIT_COUNT - 1);

	stage_t chain [DIGIT_COUNT+1];
	stage_t in_s1;
	logic   neg_d;

	assign busy  = 1'b0;
	assign neg_d = (mode_t'(mode) == MODE_SDEC) && value[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else begin
			in_s1.valid     <= start && !busy;
			in_s1.mode      <= mode_t'(mode);
			in_s1.mag       <= neg_d ? (32'd0 - value) : value;
			in_s1.neg       <= neg_d;
			in_s1.sign_done <= 1'b0;
			in_s1.text      <= text_chars;
			in_s1.seg       <= '0;
		end
	end

	assign chain[0] = in_s1;

	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
		ssnf_cell #(
			.POS       (DIGIT_COUNT - 1 - i),
			.RIGHTMOST (i == 0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	assign done     = chain[DIGIT_COUNT].valid;
	assign segments = chain[DIGIT_COUNT].seg;

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, DIGIT_COUNT + 1))
		else $error("result without a request");

	a_rightmost_lit: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(mode, DIGIT_COUNT + 1) != MODE_TEXT)
		|-> (segments[RIGHT_LSB +: 8] != SEG_BLANK))
		else $error("rightmost numeric digit blank");

	a_no_dp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((segments & 64'h8080_8080_8080_8080) == 64'd0))
		else $error("decimal point bit set");

endmodule

>>> sim/tb_seven_segment_number_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_number_formatter
// Drives formatting requests in all four display modes with random gaps and
// bursts. A scoreboard forms the eight expected digit codes of each accepted
// transaction and compares them with every segments strobe in order.
// ----------------------------------------------------------------------------
module tb_seven_segment_number_formatter;
	import ssnf_pkg::*;

	localparam int RANDOM_ITEMS = 1425;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 150000;

	class segment_scoreboard;
		localparam int DIGITS = 8;

		typedef struct {
			mode_t       mode;
			logic [31:0] value;
			logic [63:0] text_chars;
			logic [63:0] segments;
		} request_t;

		request_t awaited_displays[$];
		int       errors = 0;

		function logic [7:0] decimal_glyph(int unsigned d);
			case (d)
				0: return 8'h3F;
				1: return 8'h06;
				2: return 8'h5B;
				3: return 8'h4F;
				4: return 8'h66;
				5: return 8'h6D;
				6: return 8'h7D;
				7: return 8'h07;
				8: return 8'h7F;
				default: return 8'h6F;
			endcase
		endfunction

		function logic [7:0] letter_glyph(int unsigned idx);
			case (idx)
				0: return 8'h77;
				1: return 8'h7C;
				2: return 8'h39;
				3: return 8'h5E;
				4: return 8'h79;
				5: return 8'h71;
				6: return 8'h3D;
				7: return 8'h76;
				8: return 8'h06;
				9: return 8'h1E;
				10: return 8'h75;
				11: return 8'h38;
				12: return 8'h37;
				13: return 8'h54;
				14: return 8'h3F;
				15: return 8'h73;
				16: return 8'h67;
				17: return 8'h50;
				18: return 8'h6D;
				19: return 8'h78;
				20: return 8'h3E;
				21: return 8'h3E;
				22: return 8'h2A;
				23: return 8'h76;
				24: return 8'h6E;
				default: return 8'h5B;
			endcase
		endfunction

		function logic [7:0] char_code(logic [7:0] ch);
			if (ch >= 8'h30 && ch <= 8'h39) begin
				return decimal_glyph(32'(ch - 8'h30));
			end
			if (ch >= 8'h41 && ch <= 8'h5A) begin
				return letter_glyph(32'(ch - 8'h41));
			end
			if (ch >= 8'h61 && ch <= 8'h7A) begin
				return letter_glyph(32'(ch - 8'h61));
			end
			if (ch == 8'h2D) begin
				return 8'h40;
			end
			if (ch == 8'h5F) begin
				return 8'h08;
			end
			if (ch == 8'h3D) begin
				return 8'h48;
			end
			return 8'h00;
		endfunction

		function logic [63:0] render_segments(mode_t m, logic [31:0] v, logic [63:0] t);
			logic [7:0]  digit_code [8];
			logic [31:0] mag;
			logic [31:0] rest;
			logic [63:0] code;
			logic        neg;
			logic        ended;
			int          pos;
			for (int i = 0; i < 8; i++) begin
				digit_code[i] = 8'h00;
			end
			rest = v;
			case (m)
				MODE_SDEC: begin
					if (v == 32'd0) begin
						digit_code[DIGITS - 1] = decimal_glyph(0);
					end else begin
						neg = v[31];
						mag = neg ? 32'd0 - v : v;
						pos = DIGITS;
						while (mag != 32'd0 && pos > 0) begin
							pos--;
							digit_code[pos] = decimal_glyph(mag % 10);
							mag = mag / 10;
						end
						// drop the sign when every position holds a digit
						if (neg && pos > 0) begin
							digit_code[pos - 1] = 8'h40;
						end
					end
				end
				MODE_UDEC: begin
					for (int i = DIGITS - 1; i >= 0; i--) begin
						digit_code[i] = decimal_glyph(rest % 10);
						rest = rest / 10;
					end
				end
				MODE_HEX: begin
					for (int i = DIGITS - 1; i >= 0; i--) begin
						digit_code[i] = (rest[3:0] < 4'd10) ?
							decimal_glyph(32'(rest[3:0])) :
							letter_glyph(32'(rest[3:0] - 4'd10));
						rest = rest >> 4;
					end
				end
				default: begin
					ended = 1'b0;
					for (int i = 0; i < DIGITS; i++) begin
						if (t[8*i +: 8] == 8'h00) begin
							ended = 1'b1;
						end
						digit_code[i] = ended ? 8'h00 : char_code(t[8*i +: 8]);
					end
				end
			endcase
			for (int i = 0; i < 8; i++) begin
				code[8*i +: 8] = digit_code[i];
			end
			return code;
		endfunction

		function int pending();
			return awaited_displays.size();
		endfunction

		function void note_request(mode_t m, logic [31:0] v, logic [63:0] t);
			request_t r;
			r.mode       = m;
			r.value      = v;
			r.text_chars = t;
			r.segments   = render_segments(m, v, t);
			awaited_displays.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [63:0] got);
			request_t r;
			if (awaited_displays.size() == 0) begin
				report($sformatf("result with no request pending: segments %h", got));
			end else begin
				r = awaited_displays.pop_front();
				if (got !== r.segments) begin
					report($sformatf("mode %s value %h text %h: segments %h, want %h",
						r.mode.name(), r.value, r.text_chars, got, r.segments));
				end
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	mode_t       mode;
	logic [31:0] value;
	logic [63:0] text_chars;
	logic        done;
	logic [63:0] segments;
	logic        burst;
	int          cycle_count;

	segment_scoreboard sb = new();

	seven_segment_number_formatter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.value      (value),
		.text_chars (text_chars),
		.done       (done),
		.segments   (segments)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_request(mode, value, text_chars);
			end
			if (done) begin
				sb.check_result(segments);
			end
		end
	end

	function automatic logic [31:0] random_number();
		case ($urandom_range(0, 6))
			0: return $urandom;
			1: return $urandom_range(0, 999);
			2: return $urandom_range(0, 99999999);
			3: return 32'd0 - 32'($urandom_range(1, 9999999));
			4: return 32'd0 - 32'($urandom_range(1, 999999999));
			5: return $urandom_range(0, 1) ? 32'h8000_0000 + 32'($urandom_range(0, 15)) :
				32'hFFFF_FFFF - 32'($urandom_range(0, 15));
			default: return $urandom_range(90000000, 110000000);
		endcase
	endfunction

	function automatic logic [63:0] random_text();
		string       charset = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-_=";
		logic [63:0] t;
		int          stop;
		if ($urandom_range(0, 4) == 0) begin
			return {$urandom, $urandom};
		end
		// terminate at a random position, or not at all
		stop = $urandom_range(0, 11);
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 9) < 2) begin
				t[8*i +: 8] = 8'($urandom);
			end else begin
				t[8*i +: 8] = charset[$urandom_range(0, charset.len() - 1)];
			end
			if (i == stop) begin
				t[8*i +: 8] = 8'h00;
			end
		end
		return t;
	endfunction

	task automatic send_request(mode_t m, logic [31:0] v, logic [63:0] t);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		mode       <= m;
		value      <= v;
		text_chars <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_seven_segment_number_formatter: errors");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		mode       <= MODE_SDEC;
		value      <= 32'd0;
		text_chars <= 64'd0;
		burst      <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_SDEC, 32'd0, random_text());
		send_request(MODE_SDEC, 32'd1, random_text());
		send_request(MODE_SDEC, 32'hFFFF_FFFF, random_text());
		send_request(MODE_SDEC, 32'h7FFF_FFFF, random_text());
		send_request(MODE_SDEC, 32'h8000_0000, random_text());
		send_request(MODE_SDEC, 32'd99999999, random_text());
		send_request(MODE_SDEC, 32'd100000000, random_text());
		send_request(MODE_SDEC, 32'(-9999999), random_text());
		send_request(MODE_SDEC, 32'(-99999999), random_text());
		send_request(MODE_SDEC, 32'd12345, random_text());
		send_request(MODE_UDEC, 32'd0, random_text());
		send_request(MODE_UDEC, 32'hFFFF_FFFF, random_text());
		send_request(MODE_UDEC, 32'd12345678, random_text());
		send_request(MODE_HEX, 32'd0, random_text());
		send_request(MODE_HEX, 32'hFFFF_FFFF, random_text());
		send_request(MODE_HEX, 32'h89AB_CDEF, random_text());
		send_request(MODE_HEX, 32'h0123_4567, random_text());
		send_request(MODE_TEXT, random_number(), 64'h0000_004F_4C4C_4548);
		send_request(MODE_TEXT, random_number(), 64'h3D5F_2D6F_6C6C_6568);
		send_request(MODE_TEXT, random_number(), 64'hFF80_7E3F_7A39_4021);
		send_request(MODE_TEXT, random_number(), 64'h4142_4344_4546_4700);
		send_request(MODE_TEXT, random_number(), 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(MODE_TEXT, random_number(), 64'd0);
		send_request(MODE_TEXT, random_number(), 64'h4847_4645_4443_4241);
		send_request(MODE_TEXT, random_number(), 64'h3534_3332_315A_5950);
		wait_for_results();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 150 == 0) begin
				burst <= ($urandom_range(0, 2) == 0);
			end
			if (k == RANDOM_ITEMS / 2) begin
				wait_for_results();
			end
			send_request(mode_t'($urandom_range(0, 3)), random_number(), random_text());
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_seven_segment_number_formatter: clean");
		end else begin
			$display("tb_seven_segment_number_formatter: errors");
		end
		$finish;
	end

endmodule

>>> seven_segment_number_formatter.f
hdl/ssnf_pkg.sv
hdl/ssnf_cell.sv
hdl/seven_segment_number_formatter.sv
sim/tb_seven_segment_number_formatter.sv
